// ----- sv/lzd_pkg.sv -----
// Package for the LZ copy/literal replay decoder.
// Payload widths, item modes, status codes and job kinds.
// No dependencies.
package lzd_pkg;

  localparam int unsigned SEG_W    = 48;
  localparam int unsigned DELTA_W  = 49;
  localparam int unsigned RUN_W    = 7;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OUTPOS_W = 48;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [1:0] {
    MD_SEG  = 2'd0,
    MD_LIT  = 2'd1,
    MD_COPY = 2'd2,
    MD_CONT = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_BAD_SRC = 3'd1,
    ST_OVERRUN = 3'd2,
    ST_WINDOW  = 3'd3,
    ST_SHORT   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    JK_ERR  = 2'd0,
    JK_LIT  = 2'd1,
    JK_COPY = 2'd2
  } job_kind_e;

endpackage

// ----- sv/lzd_if.sv -----
// Valid/ready channel interfaces of the replay decoder: token input, byte output.
// Depends on lzd_pkg for the payload widths.
interface lzd_in_if import lzd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [SEG_W-1:0]   segment_bytes;
  logic               offset_select;
  logic [BYTE_W-1:0]  lit_value;
  logic [DELTA_W-1:0] delta_code;
  logic [RUN_W-1:0]   run_length;

  modport source (
    output valid, mode, segment_bytes, offset_select, lit_value, delta_code, run_length,
    input  ready
  );
  modport sink (
    input  valid, mode, segment_bytes, offset_select, lit_value, delta_code, run_length,
    output ready
  );
endinterface

interface lzd_out_if import lzd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   out_byte;
  logic [OUTPOS_W-1:0] out_position;
  logic                last;
  logic                segment_done;
  logic [STATUS_W-1:0] status;

  modport source (
    output valid, out_byte, out_position, last, segment_done, status,
    input  ready
  );
  modport sink (
    input  valid, out_byte, out_position, last, segment_done, status,
    output ready
  );
endinterface

// ----- sv/lzd_queue.sv -----
// Small job queue between the decoder front and back.
// Generic over the job type; no package dependencies.
module lzd_queue #(
  parameter type         job_t = logic,
  parameter int unsigned DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t data_o,
  output logic empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          slots_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- sv/lzd_front.sv -----
// Decoder front: accepts tokens, resolves copy sources, runs the checks and
// keeps the position and predictor state. Depends on lzd_pkg and lzd_in_if.
module lzd_front import lzd_pkg::*; #(
  parameter int unsigned HISTORY_BYTES = 65536,
  parameter int unsigned MAX_COPY      = 64,
  parameter int unsigned POS_BITS      = 48,
  parameter type         job_t         = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  lzd_in_if.sink in_i,
  output logic job_valid_o,
  output job_t job_o,
  input  logic job_ready_i
);

  localparam int unsigned AW    = (HISTORY_BYTES > 1) ? $clog2(HISTORY_BYTES) : 1;
  localparam int unsigned AW1   = AW + 1;
  localparam int unsigned DW    = $clog2(HISTORY_BYTES + 1);
  localparam int unsigned SW    = DW + 1;
  localparam int unsigned P1    = POS_BITS + 1;
  localparam int unsigned WideW = 64;

  typedef logic [POS_BITS-1:0] pos_t;

  typedef enum logic [3:0] {
    FS_IDLE = 4'b0001,
    FS_SRC  = 4'b0010,
    FS_DIST = 4'b0100,
    FS_CHK  = 4'b1000
  } front_state_e;

  front_state_e        state_q, state_d;
  mode_e               mode_q;
  logic [SEG_W-1:0]    seg_bytes_q;
  logic                sel_q;
  logic [BYTE_W-1:0]   lit_q;
  logic [DELTA_W-1:0]  delta_code_q;
  logic [RUN_W-1:0]    len_q, len_sat;

  pos_t                wpos_q, wpos_d, send_q, send_d, pse_q, pse_d;
  pos_t                poff_q, poff_d, csrc_q, csrc_d;
  logic                smode_q, smode_d;
  logic [AW-1:0]       widx_q, widx_d;

  pos_t                src_q, src_d, dist_q, remain_q;
  logic                src_lt_q;

  logic [WideW-1:0]    mag_w, delta_w;
  pos_t                delta_p;
  logic                accept, commit, has_res, far, len_fits;
  logic [AW1-1:0]      inc, widx_sum;
  logic [P1-1:0]       pos_sum;
  logic [SW-1:0]       sidx_t;
  job_t                job;

  assign in_i.ready = (state_q == FS_IDLE);
  assign accept     = in_i.valid && (state_q == FS_IDLE);
  assign len_sat    = (in_i.run_length > RUN_W'(MAX_COPY)) ? RUN_W'(MAX_COPY) : in_i.run_length;

  assign mag_w   = WideW'(delta_code_q[DELTA_W-1:1]);
  assign delta_w = delta_code_q[0] ? ~mag_w : mag_w;
  assign delta_p = delta_w[POS_BITS-1:0];

  always_comb begin
    src_d = csrc_q;
    if (mode_q == MD_COPY) begin
      src_d = smode_q ? (wpos_q - (poff_q + delta_p)) : (pse_q + delta_p);
    end
  end

  always_comb begin
    job      = '0;
    has_res  = 1'b0;
    wpos_d   = wpos_q;
    widx_d   = widx_q;
    send_d   = send_q;
    smode_d  = smode_q;
    pse_d    = pse_q;
    poff_d   = poff_q;
    csrc_d   = csrc_q;

    inc = AW1'(len_q);
    if (mode_q == MD_LIT) begin
      inc = AW1'(1);
    end
    pos_sum  = P1'(wpos_q) + P1'(inc);
    widx_sum = AW1'(widx_q) + inc;
    if (widx_sum >= AW1'(HISTORY_BYTES)) begin
      widx_sum = widx_sum - AW1'(HISTORY_BYTES);
    end
    sidx_t = SW'(widx_q) - SW'(dist_q);
    if (sidx_t[SW-1]) begin
      sidx_t = sidx_t + SW'(HISTORY_BYTES);
    end
    far      = WideW'(dist_q) > WideW'(HISTORY_BYTES);
    len_fits = WideW'(len_q) <= WideW'(remain_q);

    job.kind    = JK_ERR;
    job.status  = ST_OK;
    job.dst_pos = wpos_q;
    job.dst_idx = widx_q;

    case (mode_q)
      MD_SEG: begin
        has_res    = (remain_q != '0);
        job.status = ST_SHORT;
        send_d     = wpos_q + pos_t'(seg_bytes_q);
        smode_d    = sel_q;
        pse_d      = '0;
        poff_d     = '0;
        csrc_d     = '0;
      end
      MD_LIT: begin
        has_res = 1'b1;
        if (remain_q == '0) begin
          job.status = ST_OVERRUN;
        end else begin
          job.kind     = JK_LIT;
          job.lit_byte = lit_q;
          job.seg_done = (remain_q == pos_t'(1));
          wpos_d       = pos_sum[POS_BITS-1:0];
          widx_d       = pos_sum[POS_BITS] ? AW'(pos_sum[POS_BITS-1:0]) : widx_sum[AW-1:0];
        end
      end
      default: begin
        has_res = 1'b1;
        if (!src_lt_q) begin
          job.status = ST_BAD_SRC;
        end else if (far) begin
          job.status = ST_WINDOW;
        end else if (!len_fits) begin
          job.status = ST_OVERRUN;
        end else begin
          has_res      = (len_q != '0);
          job.kind     = JK_COPY;
          job.src_pos  = src_q;
          job.src_idx  = sidx_t[AW-1:0];
          job.len      = len_q;
          job.seg_done = (WideW'(len_q) == WideW'(remain_q));
          csrc_d       = src_q + pos_t'(len_q);
          pse_d        = src_q + pos_t'(len_q);
          poff_d       = dist_q;
          wpos_d       = pos_sum[POS_BITS-1:0];
          widx_d       = pos_sum[POS_BITS] ? AW'(pos_sum[POS_BITS-1:0]) : widx_sum[AW-1:0];
        end
      end
    endcase
  end

  assign commit      = (state_q == FS_CHK) && (!has_res || job_ready_i);
  assign job_valid_o = (state_q == FS_CHK) && has_res;
  assign job_o       = job;

  always_comb begin
    state_d = state_q;
    case (state_q)
      FS_IDLE: if (accept) state_d = FS_SRC;
      FS_SRC:  state_d = FS_DIST;
      FS_DIST: state_d = FS_CHK;
      FS_CHK:  if (commit) state_d = FS_IDLE;
      default: state_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      wpos_q  <= '0;
      widx_q  <= '0;
      send_q  <= '0;
      smode_q <= 1'b0;
      pse_q   <= '0;
      poff_q  <= '0;
      csrc_q  <= '0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        wpos_q  <= wpos_d;
        widx_q  <= widx_d;
        send_q  <= send_d;
        smode_q <= smode_d;
        pse_q   <= pse_d;
        poff_q  <= poff_d;
        csrc_q  <= csrc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q       <= mode_e'(in_i.mode);
      seg_bytes_q  <= in_i.segment_bytes;
      sel_q        <= in_i.offset_select;
      lit_q        <= in_i.lit_value;
      delta_code_q <= in_i.delta_code;
      len_q        <= len_sat;
    end
    if (state_q == FS_SRC) begin
      src_q <= src_d;
    end
    if (state_q == FS_DIST) begin
      dist_q   <= wpos_q - src_q;
      remain_q <= send_q - wpos_q;
      src_lt_q <= (src_q < wpos_q);
    end
  end

endmodule

// ----- sv/lzd_back.sv -----
// Decoder back: replays jobs into bytes via the history memory, one byte per
// cycle while out_o is ready, output registered. Needs lzd_pkg, lzd_out_if.
module lzd_back import lzd_pkg::*; #(
  parameter int unsigned HISTORY_BYTES = 65536,
  parameter int unsigned POS_BITS      = 48,
  parameter type         job_t         = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_empty_i,
  input  job_t q_job_i,
  output logic q_pop_o,
  lzd_out_if.source out_o
);

  localparam int unsigned AW = (HISTORY_BYTES > 1) ? $clog2(HISTORY_BYTES) : 1;

  typedef logic [POS_BITS-1:0] pos_t;

  logic [BYTE_W-1:0]   hist_mem [HISTORY_BYTES];

  job_t                act_q, act_d, cur;
  logic                busy_q, busy_d;
  logic                adv, have, go, mem_re, mem_we;
  pos_t                src_pos_n, dst_pos_n;

  logic                e_valid_q, e_mem_q, e_write_q, e_last_q, e_done_q;
  logic                e_mem_d, e_write_d, e_last_d, e_done_d;
  logic [STATUS_W-1:0] e_status_q;
  logic [BYTE_W-1:0]   e_byte_q, e_data;
  pos_t                e_pos_q;
  logic [AW-1:0]       e_idx_q;

  logic [BYTE_W-1:0]   rd_q, byp_data_q;
  logic                byp_q, byp_d;

  logic                out_valid_q, out_last_q, out_done_q;
  logic [BYTE_W-1:0]   out_byte_q;
  logic [OUTPOS_W-1:0] out_pos_q;
  logic [STATUS_W-1:0] out_status_q;

  assign adv     = !out_valid_q || out_o.ready;
  assign have    = busy_q || !q_empty_i;
  assign cur     = busy_q ? act_q : q_job_i;
  assign go      = adv && have;
  assign q_pop_o = adv && !busy_q && !q_empty_i;

  assign e_data  = e_mem_q ? (byp_q ? byp_data_q : rd_q) : e_byte_q;
  assign mem_we  = adv && e_valid_q && e_write_q;
  assign mem_re  = go && (cur.kind == JK_COPY);
  assign byp_d   = mem_we && (cur.src_idx == e_idx_q);

  assign e_mem_d   = (cur.kind == JK_COPY);
  assign e_write_d = (cur.kind != JK_ERR);
  assign e_last_d  = (cur.kind != JK_COPY) || (cur.len == RUN_W'(1));
  assign e_done_d  = cur.seg_done && e_last_d;

  assign src_pos_n = cur.src_pos + pos_t'(1);
  assign dst_pos_n = cur.dst_pos + pos_t'(1);

  // advance the running copy by one byte
  always_comb begin
    act_d         = cur;
    act_d.len     = cur.len - RUN_W'(1);
    act_d.src_pos = src_pos_n;
    act_d.dst_pos = dst_pos_n;
    if (src_pos_n == '0 || cur.src_idx == AW'(HISTORY_BYTES - 1)) begin
      act_d.src_idx = '0;
    end else begin
      act_d.src_idx = cur.src_idx + AW'(1);
    end
    if (dst_pos_n == '0 || cur.dst_idx == AW'(HISTORY_BYTES - 1)) begin
      act_d.dst_idx = '0;
    end else begin
      act_d.dst_idx = cur.dst_idx + AW'(1);
    end
    busy_d = (cur.kind == JK_COPY) && (cur.len != RUN_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      e_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (go) begin
        busy_q <= busy_d;
      end
      if (adv) begin
        e_valid_q   <= have;
        out_valid_q <= e_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      act_q      <= act_d;
      e_mem_q    <= e_mem_d;
      e_write_q  <= e_write_d;
      e_last_q   <= e_last_d;
      e_done_q   <= e_done_d;
      e_status_q <= cur.status;
      e_byte_q   <= cur.lit_byte;
      e_pos_q    <= cur.dst_pos;
      e_idx_q    <= cur.dst_idx;
    end
    if (adv && e_valid_q) begin
      out_byte_q   <= e_data;
      out_pos_q    <= OUTPOS_W'(e_pos_q);
      out_last_q   <= e_last_q;
      out_done_q   <= e_done_q;
      out_status_q <= e_status_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[e_idx_q] <= e_data;
    end
    if (mem_re) begin
      rd_q       <= hist_mem[cur.src_idx];
      byp_q      <= byp_d;
      byp_data_q <= e_data;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_byte     = out_byte_q;
  assign out_o.out_position = out_pos_q;
  assign out_o.last         = out_last_q;
  assign out_o.segment_done = out_done_q;
  assign out_o.status       = out_status_q;

endmodule

// ----- sv/lz_copy_literal_replay_decoder.sv -----
// Top level of the LZ copy/literal replay decoder: front, job queue, back.
// Depends on lzd_pkg, lzd_if, lzd_front, lzd_queue and lzd_back.
//
//   channel  | port  | dir | beat
//   ---------+-------+-----+----------------------------------------------
//   tokens   | in_i  | in  | one token: segment start, literal or copy
//   bytes    | out_o | out | one output byte or one error report
//
// The front takes each token through accept, source, distance and check.
// The back sends one byte per cycle while out_o is ready, copies from the
// history memory, and a 4-entry job queue lets the front run ahead.
// Reset clears positions, predictors and handshakes; the history memory is
// not cleared and needs no pass. The output register holds while out_o stalls.
module lz_copy_literal_replay_decoder import lzd_pkg::*; #(
  parameter int unsigned HISTORY_BYTES = 65536,
  parameter int unsigned MAX_COPY      = 64,
  parameter int unsigned POS_BITS      = 48
) (
  input  logic clk_i,
  input  logic rst_ni,
  lzd_in_if.sink    in_i,
  lzd_out_if.source out_o
);

  localparam int unsigned AW         = (HISTORY_BYTES > 1) ? $clog2(HISTORY_BYTES) : 1;
  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    job_kind_e           kind;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   lit_byte;
    logic [POS_BITS-1:0] src_pos;
    logic [AW-1:0]       src_idx;
    logic [POS_BITS-1:0] dst_pos;
    logic [AW-1:0]       dst_idx;
    logic [RUN_W-1:0]    len;
    logic                seg_done;
  } job_t;

  logic job_valid, q_full, q_empty, q_pop;
  job_t front_job, q_job;

  lzd_front #(
    .HISTORY_BYTES (HISTORY_BYTES),
    .MAX_COPY      (MAX_COPY),
    .POS_BITS      (POS_BITS),
    .job_t         (job_t)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .job_valid_o (job_valid),
    .job_o       (front_job),
    .job_ready_i (!q_full)
  );

  lzd_queue #(
    .job_t (job_t),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .data_i  (front_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_job),
    .empty_o (q_empty)
  );

  lzd_back #(
    .HISTORY_BYTES (HISTORY_BYTES),
    .POS_BITS      (POS_BITS),
    .job_t         (job_t)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_job_i   (q_job),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

// ----- bench/lzd_checker.sv -----
// Scoreboard for the LZ copy/literal replay decoder: watches the token and byte channels.
// Predicts every byte beat from accepted tokens and compares in order; depends on lzd_pkg
// and the lzd_in_if / lzd_out_if channel interfaces.
module lzd_checker import lzd_pkg::*; #(
  parameter int unsigned HISTORY_BYTES = 65536,
  parameter int unsigned MAX_COPY      = 64,
  parameter int unsigned POS_BITS      = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lzd_in_if           tok_i,
  lzd_out_if          byte_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [POS_BITS-1:0] pos_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   data;
    logic [OUTPOS_W-1:0] pos;
    logic                last;
    logic                done;
    status_e             status;
  } byte_beat_t;

  byte_beat_t        byte_beats_q[$];
  logic [BYTE_W-1:0] hist_mem [HISTORY_BYTES];
  pos_t              wr_pos;
  pos_t              seg_end;
  pos_t              prev_end;
  pos_t              last_off;
  pos_t              cont_src;
  logic              src_rel;
  int unsigned       fails;

  task automatic add_beat(input byte_beat_t bt);
    byte_beats_q.insert(byte_beats_q.size(), bt);
  endtask

  task automatic push_error(input status_e st);
    add_beat('{data: '0, pos: wr_pos, last: 1'b1, done: 1'b0, status: st});
  endtask

  task automatic replay_copy(input pos_t src, input logic [RUN_W-1:0] run);
    pos_t              len;
    pos_t              back_dist;
    pos_t              remain;
    pos_t              s;
    pos_t              d;
    logic [BYTE_W-1:0] b;
    len       = (run > MAX_COPY) ? pos_t'(MAX_COPY) : pos_t'(run);
    back_dist = wr_pos - src;
    remain    = seg_end - wr_pos;
    if (src >= wr_pos) begin
      push_error(ST_BAD_SRC);
    end else if (back_dist > pos_t'(HISTORY_BYTES)) begin
      push_error(ST_WINDOW);
    end else if (len > remain) begin
      push_error(ST_OVERRUN);
    end else begin
      for (pos_t i = 0; i < len; i++) begin
        s = src + i;
        d = wr_pos + i;
        b = hist_mem[s % HISTORY_BYTES];
        hist_mem[d % HISTORY_BYTES] = b;
        add_beat('{data: b, pos: d, last: (i + 1'b1 == len),
                   done: (i + 1'b1 == remain), status: ST_OK});
      end
      cont_src = src + len;
      prev_end = cont_src;
      last_off = back_dist;
      wr_pos   = wr_pos + len;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    byte_beat_t got;
    byte_beat_t want;
    pos_t       delta;
    pos_t       src;
    if (!rst_ni) begin
      byte_beats_q.delete();
      wr_pos       = '0;
      seg_end      = '0;
      prev_end     = '0;
      last_off     = '0;
      cont_src     = '0;
      src_rel      = 1'b0;
      fails        = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (byte_i.valid && byte_i.ready) begin
        got = '{data: byte_i.out_byte, pos: byte_i.out_position, last: byte_i.last,
                done: byte_i.segment_done, status: status_e'(byte_i.status)};
        if (byte_beats_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected byte beat: byte %02h pos %0d last %0b done %0b status %0d",
                   $time, got.data, got.pos, got.last, got.done, got.status);
        end else begin
          want = byte_beats_q.pop_front();
          if (got.data !== want.data || got.pos !== want.pos || got.last !== want.last ||
              got.done !== want.done || got.status !== want.status) begin
            fails++;
            $display({"%0t: byte beat mismatch: expected byte %02h pos %0d last %0b done %0b",
                      " status %0d, actual byte %02h pos %0d last %0b done %0b status %0d"},
                     $time, want.data, want.pos, want.last, want.done, want.status,
                     got.data, got.pos, got.last, got.done, got.status);
          end
        end
      end
      if (tok_i.valid && tok_i.ready) begin
        case (mode_e'(tok_i.mode))
          MD_SEG: begin
            if (wr_pos != seg_end) push_error(ST_SHORT);
            seg_end  = wr_pos + pos_t'(tok_i.segment_bytes);
            src_rel  = tok_i.offset_select;
            prev_end = '0;
            last_off = '0;
            cont_src = '0;
          end
          MD_LIT: begin
            if (wr_pos == seg_end) begin
              push_error(ST_OVERRUN);
            end else begin
              hist_mem[wr_pos % HISTORY_BYTES] = tok_i.lit_value;
              add_beat('{data: tok_i.lit_value, pos: wr_pos, last: 1'b1,
                         done: (wr_pos + 1'b1 == seg_end), status: ST_OK});
              wr_pos = wr_pos + 1'b1;
            end
          end
          MD_COPY: begin
            delta = pos_t'(tok_i.delta_code >> 1);
            if (tok_i.delta_code[0]) delta = ~delta;
            src = src_rel ? wr_pos - (last_off + delta) : prev_end + delta;
            replay_copy(src, tok_i.run_length);
          end
          default: replay_copy(cont_src, tok_i.run_length);
        endcase
      end
      fail_count_o <= fails;
      pending_o    <= byte_beats_q.size();
    end
  end

endmodule

// ----- bench/tb_top.sv -----
// Top of the replay decoder bench: clock, reset, token stimulus and byte-side back-pressure.
// Instantiates lz_copy_literal_replay_decoder and lzd_checker; needs lzd_pkg and lzd_if.
module tb_top import lzd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HIST_DEPTH = 65536;
  localparam int unsigned MAX_RUN    = 64;
  localparam int unsigned POS_W      = 48;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    mode_e              mode;
    logic [SEG_W-1:0]   seg_bytes;
    logic               rel;
    logic [BYTE_W-1:0]  lit;
    logic [DELTA_W-1:0] code;
    logic [RUN_W-1:0]   run;
  } token_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  logic        quiet_tx = 1'b0;

  pos_t plan_wp       = '0;
  pos_t plan_end      = '0;
  pos_t plan_prev_end = '0;
  pos_t plan_prev_off = '0;
  pos_t plan_cont     = '0;
  logic plan_rel      = 1'b0;

  lzd_in_if  tok_ch ();
  lzd_out_if byte_ch ();

  lz_copy_literal_replay_decoder #(
    .HISTORY_BYTES (HIST_DEPTH),
    .MAX_COPY      (MAX_RUN),
    .POS_BITS      (POS_W)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (tok_ch),
    .out_o  (byte_ch)
  );

  lzd_checker #(
    .HISTORY_BYTES (HIST_DEPTH),
    .MAX_COPY      (MAX_RUN),
    .POS_BITS      (POS_W)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tok_i        (tok_ch),
    .byte_i       (byte_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #6000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int unsigned ncyc;
    ncyc = 0;
    byte_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      ncyc++;
      byte_ch.ready <= (ncyc >= 300 && ncyc < 800) || ($urandom_range(99) >= 16);
    end
  end

  function automatic token_t noise_tok();
    token_t      t;
    logic [63:0] r;
    r           = {$urandom, $urandom};
    t.mode      = mode_e'($urandom_range(3));
    t.seg_bytes = r[SEG_W-1:0];
    t.rel       = 1'($urandom_range(1));
    t.lit       = 8'($urandom_range(255));
    r           = {$urandom, $urandom};
    t.code      = r[DELTA_W-1:0];
    t.run       = RUN_W'($urandom_range(127));
    return t;
  endfunction

  function automatic token_t make_tok(input mode_e m, input logic [RUN_W-1:0] run);
    token_t t;
    t      = noise_tok();
    t.mode = m;
    t.run  = run;
    return t;
  endfunction

  function automatic token_t seg_tok(input logic [SEG_W-1:0] n, input logic rel);
    token_t t;
    t           = make_tok(MD_SEG, RUN_W'($urandom_range(127)));
    t.seg_bytes = n;
    t.rel       = rel;
    return t;
  endfunction

  function automatic token_t lit_tok(input logic [BYTE_W-1:0] v);
    token_t t;
    t     = make_tok(MD_LIT, RUN_W'($urandom_range(127)));
    t.lit = v;
    return t;
  endfunction

  function automatic token_t copy_tok(input pos_t src, input logic [RUN_W-1:0] run);
    token_t t;
    pos_t   d;
    d      = plan_rel ? (plan_wp - src) - plan_prev_off : src - plan_prev_end;
    t      = make_tok(MD_COPY, run);
    t.code = $urandom_range(1) ? {d, 1'b0} : {~d, 1'b1};
    return t;
  endfunction

  task automatic plan_copy(input pos_t src, input logic [RUN_W-1:0] run);
    pos_t len;
    len = (run > MAX_RUN) ? pos_t'(MAX_RUN) : pos_t'(run);
    if (src < plan_wp && plan_wp - src <= pos_t'(HIST_DEPTH) && len <= plan_end - plan_wp) begin
      plan_cont     = src + len;
      plan_prev_end = plan_cont;
      plan_prev_off = plan_wp - src;
      plan_wp       = plan_wp + len;
    end
  endtask

  task automatic send_tok(input token_t t);
    pos_t src;
    if (!quiet_tx && $urandom_range(99) < 30) begin
      tok_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    case (t.mode)
      MD_SEG: begin
        plan_end      = plan_wp + pos_t'(t.seg_bytes);
        plan_rel      = t.rel;
        plan_prev_end = '0;
        plan_prev_off = '0;
        plan_cont     = '0;
      end
      MD_LIT: if (plan_wp != plan_end) plan_wp = plan_wp + 1'b1;
      MD_COPY: begin
        src = t.code[0] ? ~pos_t'(t.code >> 1) : pos_t'(t.code >> 1);
        src = plan_rel ? plan_wp - (plan_prev_off + src) : plan_prev_end + src;
        plan_copy(src, t.run);
      end
      default: plan_copy(plan_cont, t.run);
    endcase
    tok_ch.valid         <= 1'b1;
    tok_ch.mode          <= t.mode;
    tok_ch.segment_bytes <= t.seg_bytes;
    tok_ch.offset_select <= t.rel;
    tok_ch.lit_value     <= t.lit;
    tok_ch.delta_code    <= t.code;
    tok_ch.run_length    <= t.run;
    do @(posedge clk_i); while (tok_ch.ready !== 1'b1);
  endtask

  task automatic drain();
    tok_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    token_t      t;
    int unsigned pick;
    int unsigned maxd;
    int unsigned len_max;
    int unsigned run;
    pos_t        room;
    logic [63:0] r;
    tok_ch.valid         <= 1'b0;
    tok_ch.mode          <= MD_SEG;
    tok_ch.segment_bytes <= '0;
    tok_ch.offset_select <= 1'b0;
    tok_ch.lit_value     <= '0;
    tok_ch.delta_code    <= '0;
    tok_ch.run_length    <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_tok(seg_tok(SEG_W'(40), 1'b0));
    send_tok(lit_tok(8'h00));
    send_tok(lit_tok(8'hFF));
    send_tok(lit_tok(8'hA5));
    send_tok(copy_tok(pos_t'(0), 7'd0));
    send_tok(copy_tok(pos_t'(2), 7'd5));
    send_tok(make_tok(MD_CONT, 7'd100));
    send_tok(copy_tok(plan_wp, 7'd4));
    t      = make_tok(MD_COPY, 7'd1);
    t.code = '1;
    send_tok(t);
    t      = make_tok(MD_COPY, 7'd2);
    t.code = {{(DELTA_W-1){1'b1}}, 1'b0};
    send_tok(t);
    send_tok(make_tok(MD_CONT, 7'd64));
    send_tok(make_tok(MD_CONT, RUN_W'(plan_end - plan_wp)));
    send_tok(copy_tok(pos_t'(0), 7'd1));
    send_tok(lit_tok(8'h5A));
    send_tok(seg_tok('1, 1'b1));
    send_tok(copy_tok(plan_wp - 1'b1, 7'd64));
    t      = make_tok(MD_COPY, 7'd8);
    t.code = DELTA_W'(3);
    send_tok(t);
    send_tok(seg_tok('0, 1'b0));
    send_tok(copy_tok(pos_t'(0), 7'd0));
    send_tok(seg_tok(SEG_W'(3), 1'b1));
    send_tok(lit_tok(8'h01));
    send_tok(lit_tok(8'h80));
    send_tok(lit_tok(8'h7F));
    send_tok(make_tok(MD_CONT, 7'd0));
    drain();

    for (int n = 0; n < 80; n++) begin
      quiet_tx = (n >= 30 && n < 55);
      pick     = $urandom_range(99);
      room     = plan_end - plan_wp;
      if (room == 0 || pick < 4) begin
        r = {$urandom, $urandom};
        t = seg_tok(pick < 2 ? r[SEG_W-1:0] : SEG_W'($urandom_range(400, 1)),
                    1'($urandom_range(1)));
      end else if (pick < 14) begin
        t = noise_tok();
      end else if (pick < 40 || plan_wp == 0) begin
        t = lit_tok(8'($urandom_range(255)));
      end else begin
        maxd    = (plan_wp > 600) ? 600 : int'(plan_wp);
        len_max = (room > 64) ? 64 : int'(room);
        if ($urandom_range(3) == 0 || len_max < 8) run = $urandom_range(len_max, 1);
        else run = $urandom_range(8, 1);
        if (pick < 52 && plan_cont < plan_wp && plan_wp - plan_cont <= pos_t'(HIST_DEPTH))
          t = make_tok(MD_CONT, RUN_W'(run));
        else
          t = copy_tok(plan_wp - pos_t'($urandom_range(maxd, 1)), RUN_W'(run));
      end
      send_tok(t);
    end
    quiet_tx = 1'b0;
    drain();
    repeat (32) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
